@@ rtl/core/ppq_pkg.sv @@
// Shared types and constants of the priority process queue.
// Used by ppq_ctrl, ppq_cells and priority_process_queue; depends on nothing.
package ppq_pkg;

  // Queue geometry and field widths.
  localparam int DEPTH   = 32;
  localparam int ID_W    = 5;
  localparam int PRIO_W  = 8;
  localparam int KIND_W  = 2;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int OCC_W   = 6;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  // Operation codes carried in the input tuser.
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_POP    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_PEEK   = 2'd3
  } ppq_kind_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ppq_state_t;

  // Commands from the controller to the cell datapath.
  typedef struct packed {
    logic load;  // capture the incoming request
    logic exec;  // apply the captured request and load the result register
  } ppq_cmd_t;

endpackage

@@ rtl/core/ppq_ctrl.sv @@
// Controller of the priority process queue: request sequencing and result handshake.
// Depends on ppq_pkg for the state and command types.
module ppq_ctrl
  import ppq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output ppq_cmd_t cmd
);

  ppq_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // State and result-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands. A request executes once the result register is
  // free or is being emptied in the same cycle.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    in_tready     = 1'b0;
    cmd           = '0;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_r || out_tready) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

  // An accepted request is always followed by the execute state.
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_EXEC))
    else $error("accepted request did not move to execute");

  // Executing a request always presents a result next cycle.
  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid_r)
    else $error("executed request produced no result");

  // A held result is never overwritten while the receiver stalls.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !cmd.exec)
    else $error("result overwritten while stalled");

endmodule

@@ rtl/core/ppq_cells.sv @@
// Datapath of the priority process queue: a chain of entry cells that shift in
// parallel, the request register and the result register. Depends on ppq_pkg.
module ppq_cells
  import ppq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  ppq_cmd_t              cmd,
  input  logic [KIND_W-1:0]     req_kind,
  input  logic [ID_W-1:0]       req_id,
  input  logic [PRIO_W-1:0]     req_prio,
  output logic                  res_ok,
  output logic [ID_W-1:0]       res_id,
  output logic [PRIO_W-1:0]     res_prio,
  output logic [OCC_W-1:0]      res_occ
);

  // Captured request.
  ppq_kind_t          kind_r;
  logic [ID_W-1:0]    rid_r;
  logic [PRIO_W-1:0]  rprio_r;

  // Entry cells, head at index 0, and the fill count.
  logic [ID_W-1:0]    id_r   [DEPTH];
  logic [PRIO_W-1:0]  prio_r [DEPTH];
  logic [ID_W-1:0]    id_nxt   [DEPTH];
  logic [PRIO_W-1:0]  prio_nxt [DEPTH];
  logic [CNT_W-1:0]   count_r, count_nxt;

  // Result register.
  logic               ok_r, ok_nxt;
  logic [ID_W-1:0]    oid_r, oid_nxt;
  logic [PRIO_W-1:0]  oprio_r, oprio_nxt;
  logic [OCC_W-1:0]   occ_r;

  // Per-cell flags.
  logic [DEPTH-1:0]   valid;
  logic [DEPTH-1:0]   keep_ins;
  logic [DEPTH-1:0]   match;
  logic [DEPTH-1:0]   ahead;
  logic [DEPTH-1:0]   first;
  logic               full, empty, found;
  logic [PRIO_W-1:0]  sel_prio;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign found = |match;

  // Each cell compares itself against the request in parallel.
  for (genvar i = 0; i < DEPTH; i++) begin : g_flag
    assign valid[i]    = (CNT_W'(i) < count_r);
    assign keep_ins[i] = valid[i] && !(prio_r[i] < rprio_r);
    assign match[i]    = valid[i] && (id_r[i] == rid_r);
    if (i == 0) begin : g_head
      assign ahead[i] = 1'b0;
    end else begin : g_body
      assign ahead[i] = |match[i-1:0];
    end
    assign first[i] = match[i] && !ahead[i];
  end

  // Priority of the matching entry nearest the head.
  always_comb begin
    sel_prio = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_prio = sel_prio | (first[i] ? prio_r[i] : '0);
    end
  end

  // Next value of every cell: keep, take the new entry, or shift by one place.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ID_W-1:0]   dn_id, up_id;
    logic [PRIO_W-1:0] dn_prio, up_prio;
    logic              open_here;

    if (i == 0) begin : g_dn0
      assign dn_id     = id_r[i];
      assign dn_prio   = prio_r[i];
      assign open_here = 1'b1;
    end else begin : g_dn
      assign dn_id     = id_r[i-1];
      assign dn_prio   = prio_r[i-1];
      assign open_here = keep_ins[i-1];
    end
    if (i == DEPTH - 1) begin : g_up_last
      assign up_id   = id_r[i];
      assign up_prio = prio_r[i];
    end else begin : g_up
      assign up_id   = id_r[i+1];
      assign up_prio = prio_r[i+1];
    end

    always_comb begin
      id_nxt[i]   = id_r[i];
      prio_nxt[i] = prio_r[i];
      case (kind_r)
        KIND_INSERT: begin
          if (!full && !keep_ins[i]) begin
            if (open_here) begin
              id_nxt[i]   = rid_r;
              prio_nxt[i] = rprio_r;
            end else begin
              id_nxt[i]   = dn_id;
              prio_nxt[i] = dn_prio;
            end
          end
        end
        KIND_POP: begin
          if (!empty) begin
            id_nxt[i]   = up_id;
            prio_nxt[i] = up_prio;
          end
        end
        KIND_REMOVE: begin
          if (match[i] || ahead[i]) begin
            id_nxt[i]   = up_id;
            prio_nxt[i] = up_prio;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result and fill count for the request.
  always_comb begin
    ok_nxt    = 1'b0;
    oid_nxt   = '0;
    oprio_nxt = '0;
    count_nxt = count_r;
    case (kind_r)
      KIND_INSERT: begin
        if (!full) begin
          ok_nxt    = 1'b1;
          oid_nxt   = rid_r;
          oprio_nxt = rprio_r;
          count_nxt = count_r + 1'b1;
        end
      end
      KIND_POP, KIND_PEEK: begin
        if (!empty) begin
          ok_nxt    = 1'b1;
          oid_nxt   = id_r[0];
          oprio_nxt = prio_r[0];
          if (kind_r == KIND_POP) begin
            count_nxt = count_r - 1'b1;
          end
        end
      end
      KIND_REMOVE: begin
        if (found) begin
          ok_nxt    = 1'b1;
          oid_nxt   = rid_r;
          oprio_nxt = sel_prio;
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Fill count is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  // Request, cells and result payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= ppq_kind_t'(req_kind);
      rid_r   <= req_id;
      rprio_r <= req_prio;
    end
    if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        id_r[i]   <= id_nxt[i];
        prio_r[i] <= prio_nxt[i];
      end
      ok_r    <= ok_nxt;
      oid_r   <= oid_nxt;
      oprio_r <= oprio_nxt;
      occ_r   <= OCC_W'(count_nxt);
    end
  end

  assign res_ok   = ok_r;
  assign res_id   = oid_r;
  assign res_prio = oprio_r;
  assign res_occ  = occ_r;

  // The fill count never passes the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  // The head never holds a lower priority than its successor.
  a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r > CNT_W'(1)) |-> (prio_r[0] >= prio_r[1]))
    else $error("head out of priority order");

endmodule

@@ rtl/core/priority_process_queue.sv @@
// Priority process queue: sorted queue of process ids by descending priority.
// Instantiates ppq_ctrl and ppq_cells; depends on ppq_pkg.
//
// Usage: each request on the in_ stream is one operation, selected by in_tuser:
// insert, remove the head, remove a named id, or peek at the head. Every request
// gives exactly one result on the out_ stream: out_tuser is the ok flag, and
// out_tdata carries the id and priority involved and the occupancy afterwards.
// Entries of equal priority leave in arrival order. Failed operations (insert
// when full, remove or peek when empty, id not found) return a zero ok flag, id
// and priority with the occupancy unchanged, and leave the queue as it was.
// Sequence: an accepted request is captured in the request register, then applied
// in the execute state, which loads the result register. A new request is taken
// only in the idle state, after the last one has executed; the cell chain shifts
// all 32 entries in parallel in the execute state.
// Reset (rst_n low, synchronous) empties the queue and drops any pending result.
// When the receiver stalls, the result is held in the output register; one more
// request is accepted and then waits in the execute state until the result
// register is taken.
module priority_process_queue
  import ppq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [4:0] proc_id, [12:5] priority_req, rest zero
  input  logic [KIND_W-1:0]     in_tuser,   // [1:0] kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [4:0] out_id, [12:5] out_priority,
                                            // [18:13] occupancy, rest zero
  output logic                  out_tuser   // [0] ok
);

  ppq_cmd_t          cmd;
  logic [ID_W-1:0]   res_id;
  logic [PRIO_W-1:0] res_prio;
  logic [OCC_W-1:0]  res_occ;

  // Request sequencing and result handshake.
  ppq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // Entry cells and result register.
  ppq_cells u_cells (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .req_kind (in_tuser),
    .req_id   (in_tdata[ID_W-1:0]),
    .req_prio (in_tdata[ID_W+PRIO_W-1:ID_W]),
    .res_ok   (out_tuser),
    .res_id   (res_id),
    .res_prio (res_prio),
    .res_occ  (res_occ)
  );

  // Pack the result payload, lowest field first.
  assign out_tdata = {{(OUT_DATA_W - ID_W - PRIO_W - OCC_W){1'b0}}, res_occ, res_prio, res_id};

endmodule
